// ===== design/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the address slot table.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int ADDR_W         = 48;
    localparam int SLOT_W         = 3;
    localparam int OUTCOME_W      = 2;
    localparam int CFG_IDX_W      = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_VALID = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_ADDR  = CFG_IDX_W'(1);

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT     = 2'd0,
        OUT_FREE    = 2'd1,
        OUT_REPLACE = 2'd2,
        OUT_NONE    = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE,
        ST_HUNT
    } t_state;

endpackage

// ===== design/ast_if.sv =====
// ----------------------------------------------------------------------------
// ast_if
// Handshake channels of the address slot table: request, result, config.
// ----------------------------------------------------------------------------
interface ast_in_if;
    logic                       valid;
    logic                       ready;
    logic [ast_pkg::ADDR_W-1:0] source_address;

    modport source (output valid, output source_address, input ready);
    modport sink   (input valid, input source_address, output ready);
endinterface

interface ast_out_if;
    logic                          valid;
    logic                          ready;
    logic [ast_pkg::SLOT_W-1:0]    slot_index;
    logic [ast_pkg::OUTCOME_W-1:0] outcome;

    modport source (output valid, output slot_index, output outcome, input ready);
    modport sink   (input valid, input slot_index, input outcome, output ready);
endinterface

interface ast_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ast_pkg::CFG_IDX_W-1:0] index;
    logic [ast_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ast_engine.sv =====
// ----------------------------------------------------------------------------
// ast_engine
// Entry memory and the scan / allocate / replace sequencer around it.
// ----------------------------------------------------------------------------
module ast_engine #(
    parameter int SLOT_COUNT = ast_pkg::SLOT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_bound_valid,
    input  logic [ast_pkg::ADDR_W-1:0] i_bound_address,
    ast_in_if.sink                     i_in,
    ast_out_if.source                  o_out
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [FILL_W-1:0] FULL     = FILL_W'(SLOT_COUNT);

    // Entry memory: one write port, one registered read port.
    logic [ast_pkg::ADDR_W-1:0] mem [SLOT_COUNT];
    logic [ast_pkg::ADDR_W-1:0] r_q;

    ast_pkg::t_state r_state, n_state;

    logic [ast_pkg::ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]           r_ridx;
    logic                       r_dval;
    logic [IDX_W-1:0]           r_didx;
    logic                       r_hit;
    logic [IDX_W-1:0]           r_hit_idx;
    logic [SLOT_COUNT-1:0]      r_prot;
    logic [FILL_W-1:0]          r_fill;
    logic [IDX_W-1:0]           r_victim;
    logic [IDX_W-1:0]           r_vidx;
    logic [IDX_W-1:0]           r_k;

    logic                          r_out_valid;
    logic [ast_pkg::SLOT_W-1:0]    r_out_slot;
    ast_pkg::t_outcome             r_out_code;

    logic              accept;
    logic              emit_ok;
    logic              used;
    logic              res_ld;
    logic [IDX_W-1:0]  res_slot;
    ast_pkg::t_outcome res_code;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  vidx_next;

    assign accept    = i_in.valid && i_in.ready;
    assign emit_ok   = !r_out_valid || o_out.ready;
    // Entries fill from slot 0 upward and are never freed, so the used ones are a prefix.
    assign used      = FILL_W'(r_didx) < r_fill;
    assign vidx_next = (r_vidx == LAST_IDX) ? '0 : r_vidx + IDX_W'(1);

    assign i_in.ready       = (r_state == ast_pkg::ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.slot_index = r_out_slot;
    assign o_out.outcome    = r_out_code;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ast_pkg::ST_IDLE: begin
                if (accept) n_state = ast_pkg::ST_SCAN;
            end
            ast_pkg::ST_SCAN: begin
                if (r_ridx == LAST_IDX) n_state = ast_pkg::ST_LAST;
            end
            ast_pkg::ST_LAST: begin
                n_state = ast_pkg::ST_DECIDE;
            end
            ast_pkg::ST_DECIDE: begin
                if (res_ld) begin
                    n_state = ast_pkg::ST_IDLE;
                end else if (!r_hit && r_fill == FULL) begin
                    n_state = ast_pkg::ST_HUNT;
                end
            end
            ast_pkg::ST_HUNT: begin
                if (res_ld) n_state = ast_pkg::ST_IDLE;
            end
            default: n_state = ast_pkg::ST_IDLE;
        endcase
    end

    // Result and memory write decisions.
    always_comb begin
        res_ld   = 1'b0;
        res_slot = '0;
        res_code = ast_pkg::OUT_HIT;
        wr_en    = 1'b0;
        wr_addr  = r_vidx;
        case (r_state)
            ast_pkg::ST_DECIDE: begin
                if (emit_ok) begin
                    if (r_hit) begin
                        res_ld   = 1'b1;
                        res_slot = r_hit_idx;
                        res_code = ast_pkg::OUT_HIT;
                    end else if (r_fill != FULL) begin
                        res_ld   = 1'b1;
                        res_slot = IDX_W'(r_fill);
                        res_code = ast_pkg::OUT_FREE;
                        wr_en    = 1'b1;
                        wr_addr  = IDX_W'(r_fill);
                    end
                end
            end
            ast_pkg::ST_HUNT: begin
                if (emit_ok) begin
                    if (!(i_bound_valid && r_prot[r_vidx])) begin
                        res_ld   = 1'b1;
                        res_slot = r_vidx;
                        res_code = ast_pkg::OUT_REPLACE;
                        wr_en    = 1'b1;
                        wr_addr  = r_vidx;
                    end else if (r_k == LAST_IDX) begin
                        res_ld   = 1'b1;
                        res_slot = '0;
                        res_code = ast_pkg::OUT_NONE;
                    end
                end
            end
            default: begin
                res_ld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_addr;
        end
        r_q <= mem[r_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ast_pkg::ST_IDLE;
            r_fill      <= '0;
            r_victim    <= '0;
            r_out_valid <= 1'b0;
            r_dval      <= 1'b0;
            r_hit       <= 1'b0;
            r_ridx      <= '0;
        end else begin
            r_state <= n_state;
            r_dval  <= (r_state == ast_pkg::ST_SCAN);
            r_didx  <= r_ridx;

            if (accept) begin
                r_addr <= i_in.source_address;
                r_ridx <= '0;
                r_hit  <= 1'b0;
            end else if (r_state == ast_pkg::ST_SCAN) begin
                r_ridx <= r_ridx + IDX_W'(1);
            end

            // Compare the entry read in the previous cycle.
            if (r_dval) begin
                r_prot[r_didx] <= (r_q == i_bound_address);
                if (!r_hit && used && r_q == r_addr) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_didx;
                end
            end

            if (r_state == ast_pkg::ST_DECIDE && n_state == ast_pkg::ST_HUNT) begin
                r_vidx <= r_victim;
                r_k    <= '0;
            end else if (r_state == ast_pkg::ST_HUNT && emit_ok && !res_ld) begin
                r_vidx <= vidx_next;
                r_k    <= r_k + IDX_W'(1);
            end

            if (wr_en && r_state == ast_pkg::ST_DECIDE) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (wr_en && r_state == ast_pkg::ST_HUNT) begin
                r_victim <= vidx_next;
            end

            if (res_ld) begin
                r_out_valid <= 1'b1;
                r_out_slot  <= ast_pkg::SLOT_W'(res_slot);
                r_out_code  <= res_code;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/address_slot_table_core.sv =====
// A result is loaded after a full scan of the entry memory on a hit or a free-entry fill,
// and after a further round-robin hunt for a victim when the table is full and misses.
// A new address is taken only once the previous result is loaded, set by the
// single read port of the entry memory, which is scanned one entry per cycle.
// Reset is synchronous and active low; it empties the table through the fill count,
// so no clearing pass runs and the block takes an address in the first cycle after reset.
// ----------------------------------------------------------------------------
// address_slot_table_core
// Maps 48-bit station addresses to slot numbers, with round-robin replacement.
// ----------------------------------------------------------------------------
module address_slot_table_core #(
    parameter int SLOT_COUNT = ast_pkg::SLOT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ast_in_if.sink    i_in,
    ast_out_if.source o_out,
    ast_cfg_if.sink   i_cfg
);

    logic                       r_bound_valid;
    logic [ast_pkg::ADDR_W-1:0] r_bound_address;

    assign i_cfg.ready = 1'b1;

    // Writes to indexes past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_valid   <= 1'b0;
            r_bound_address <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == ast_pkg::REG_BOUND_VALID) begin
                r_bound_valid <= i_cfg.data[0];
            end else if (i_cfg.index == ast_pkg::REG_BOUND_ADDR) begin
                r_bound_address <= i_cfg.data;
            end
        end
    end

    ast_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bound_valid   (r_bound_valid),
        .i_bound_address (r_bound_address),
        .i_in            (i_in),
        .o_out           (o_out)
    );

endmodule

// ===== tb/tb_address_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_address_slot_table_core
// Self-checking bench for the address slot table. A short directed plan walks
// the table through free fills, hits, round-robin replacement, the protected
// bound peer and ignored register writes. Random phases follow, each with its
// own bound peer setting and address pool. Every result is compared with the
// plan's typed value or with a predictor that keeps its own copy of the table.
// ----------------------------------------------------------------------------
module tb_address_slot_table_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS         = ast_pkg::SLOT_COUNT_DEF;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 3 + 4;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 150;
    localparam int POOL_SIZE     = 12;

    localparam logic [ast_pkg::CFG_IDX_W-1:0] NO_REG       = '0;
    localparam logic [ast_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = ast_pkg::CFG_IDX_W'(2);
    localparam logic [ast_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;
    localparam logic [ast_pkg::ADDR_W-1:0]    ADDR_ONES    = '1;

    typedef enum logic {ROW_ADDR, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [ast_pkg::SLOT_W-1:0] slot;
        ast_pkg::t_outcome          outcome;
    } t_slot_result;

    typedef struct packed {
        t_row_kind                     kind;
        logic [ast_pkg::CFG_IDX_W-1:0] idx;
        logic [ast_pkg::ADDR_W-1:0]    val;
        logic                          typed;
        logic [ast_pkg::SLOT_W-1:0]    slot;
        ast_pkg::t_outcome             outcome;
    } t_plan_row;

    localparam int PLAN_ROWS = 34;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0000, 1'b1, 3'd0, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'hFFFF_FFFF_FFFF, 1'b1, 3'd1, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0000, 1'b1, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'hFFFF_FFFF_FFFF, 1'b1, 3'd1, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0001, 1'b1, 3'd2, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'h8000_0000_0000, 1'b1, 3'd3, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'h7FFF_FFFF_FFFF, 1'b1, 3'd4, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'hA5A5_5A5A_F00F, 1'b1, 3'd5, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'h1234_5678_9ABC, 1'b1, 3'd6, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'hFFFF_FFFF_FFFE, 1'b1, 3'd7, ast_pkg::OUT_FREE},
        '{ROW_ADDR, NO_REG, 48'h8000_0000_0000, 1'b1, 3'd3, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0002, 1'b1, 3'd0, ast_pkg::OUT_REPLACE},
        '{ROW_CFG, ast_pkg::REG_BOUND_ADDR, 48'hFFFF_FFFF_FFFF, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_CFG, ast_pkg::REG_BOUND_VALID, 48'h0000_0000_0001, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        // The victim pointer sits on the bound peer, so the next slot is taken.
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0003, 1'b1, 3'd2, ast_pkg::OUT_REPLACE},
        '{ROW_CFG, REG_SPARE_LO, 48'hFFFF_FFFF_FFFF, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_CFG, REG_SPARE_HI, 48'h0000_0000_0000, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'hFFFF_FFFF_FFFF, 1'b1, 3'd1, ast_pkg::OUT_HIT},
        '{ROW_CFG, ast_pkg::REG_BOUND_ADDR, 48'h0000_DEAD_BEEF, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0004, 1'b1, 3'd3, ast_pkg::OUT_REPLACE},
        // Only the lowest data bit enables the bound peer.
        '{ROW_CFG, ast_pkg::REG_BOUND_VALID, 48'hFFFF_FFFF_FFFE, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_CFG, ast_pkg::REG_BOUND_ADDR, 48'h7FFF_FFFF_FFFF, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0005, 1'b1, 3'd4, ast_pkg::OUT_REPLACE},
        '{ROW_CFG, ast_pkg::REG_BOUND_VALID, 48'h0000_0000_0001, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h7FFF_FFFF_FFFF, 1'b1, 3'd5, ast_pkg::OUT_REPLACE},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0006, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0007, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0008, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_0009, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_000A, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_000B, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h0000_0000_000C, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        // The pointer wraps onto the bound peer again and must step over it.
        '{ROW_ADDR, NO_REG, 48'h0000_0000_000D, 1'b0, 3'd0, ast_pkg::OUT_HIT},
        '{ROW_ADDR, NO_REG, 48'h7FFF_FFFF_FFFF, 1'b0, 3'd0, ast_pkg::OUT_HIT}
    };

    logic i_clk;
    logic i_rst_n;

    ast_in_if  in_ch ();
    ast_out_if out_ch ();
    ast_cfg_if cfg_ch ();

    address_slot_table_core #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // Predictor copy of the table and its registers.
    logic [ast_pkg::ADDR_W-1:0] tbl_addr [SLOTS];
    bit                         tbl_used [SLOTS];
    int unsigned                victim_ptr;
    bit                         bound_on;
    logic [ast_pkg::ADDR_W-1:0] bound_peer;

    t_slot_result slot_q [$];
    int           mismatches = 0;
    bit           back_to_back = 1'b0;

    function automatic t_slot_result map_address(input logic [ast_pkg::ADDR_W-1:0] a);
        t_slot_result res;
        int unsigned  idx;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_used[i] && tbl_addr[i] == a) begin
                res.slot    = ast_pkg::SLOT_W'(i);
                res.outcome = ast_pkg::OUT_HIT;
                return res;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_used[i]) begin
                tbl_addr[i] = a;
                tbl_used[i] = 1'b1;
                res.slot    = ast_pkg::SLOT_W'(i);
                res.outcome = ast_pkg::OUT_FREE;
                return res;
            end
        end
        for (int k = 0; k < SLOTS; k++) begin
            idx = (victim_ptr + k) % SLOTS;
            if (!(bound_on && tbl_addr[idx] == bound_peer)) begin
                tbl_addr[idx] = a;
                tbl_used[idx] = 1'b1;
                victim_ptr    = (idx + 1) % SLOTS;
                res.slot      = ast_pkg::SLOT_W'(idx);
                res.outcome   = ast_pkg::OUT_REPLACE;
                return res;
            end
        end
        res.slot    = '0;
        res.outcome = ast_pkg::OUT_NONE;
        return res;
    endfunction

    function automatic void apply_register(input logic [ast_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [ast_pkg::ADDR_W-1:0] data);
        if (idx == ast_pkg::REG_BOUND_VALID) begin
            bound_on = data[0];
        end else if (idx == ast_pkg::REG_BOUND_ADDR) begin
            bound_peer = data;
        end
    endfunction

    function automatic logic [ast_pkg::ADDR_W-1:0] random_address();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_address(input logic [ast_pkg::ADDR_W-1:0] a, input bit typed,
                                input t_slot_result typed_res);
        int           gap;
        t_slot_result res;
        gap = back_to_back ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          = 1'b1;
        in_ch.source_address = a;
        do @(posedge i_clk); while (!in_ch.ready);
        res = map_address(a);
        slot_q.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [ast_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ast_pkg::ADDR_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Holds the sender off until every pending result has been taken.
    task automatic wait_table_idle();
        in_ch.valid = 1'b0;
        while (slot_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: a stall is drawn per result and usually taken once the
    // result is already waiting, so the block has to hold it.
    initial begin
        t_slot_result want;
        int           stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = back_to_back ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                do @(posedge i_clk); while (!out_ch.valid);
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (slot_q.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, actual slot %0d outcome %0d",
                         $time, out_ch.slot_index, out_ch.outcome);
            end else begin
                want = slot_q.pop_front();
                if (out_ch.slot_index !== want.slot) begin
                    mismatches++;
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, out_ch.slot_index);
                end
                if (out_ch.outcome !== want.outcome) begin
                    mismatches++;
                    $display("%0t: outcome expected %0d actual %0d",
                             $time, want.outcome, out_ch.outcome);
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        t_slot_result               typed_res;
        t_slot_result               unused_res;
        logic [ast_pkg::ADDR_W-1:0] pool [POOL_SIZE];
        logic [ast_pkg::ADDR_W-1:0] a;
        logic [ast_pkg::ADDR_W-1:0] data;

        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.source_address = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        unused_res           = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_addr[i] = '0;
            tbl_used[i] = 1'b0;
        end
        victim_ptr = 0;
        bound_on   = 1'b0;
        bound_peer = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (PLAN[r]) begin
            if (PLAN[r].kind == ROW_CFG) begin
                wait_table_idle();
                write_register(PLAN[r].idx, PLAN[r].val);
            end else begin
                typed_res.slot    = PLAN[r].slot;
                typed_res.outcome = PLAN[r].outcome;
                send_address(PLAN[r].val, PLAN[r].typed, typed_res);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_table_idle();
            back_to_back = ($urandom_range(0, 3) == 0);

            // The first two phases pin the enable to its two values with the
            // other data bits at their extremes.
            if (phase == 0) begin
                data = ADDR_ONES;
            end else if (phase == 1) begin
                data = '0;
            end else begin
                data = random_address();
            end
            write_register(ast_pkg::REG_BOUND_VALID, data);

            case ($urandom_range(0, 4))
                0: data = tbl_addr[$urandom_range(0, SLOTS - 1)];
                1: data = '0;
                2: data = ADDR_ONES;
                default: data = random_address();
            endcase
            write_register(ast_pkg::REG_BOUND_ADDR, data);

            if ($urandom_range(0, 2) == 0) begin
                write_register(ast_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                               random_address());
            end

            // A pool a bit larger than the table keeps hits and replacements
            // both frequent.
            for (int i = 0; i < POOL_SIZE; i++) begin
                pool[i] = random_address();
            end
            pool[0] = ($urandom_range(0, 1) == 0) ? '0 : ADDR_ONES;
            if ($urandom_range(0, 1) == 0) begin
                pool[1] = bound_peer;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: a = pool[$urandom_range(0, POOL_SIZE - 1)];
                    4, 5:       a = tbl_addr[$urandom_range(0, SLOTS - 1)];
                    6, 7:       a = random_address();
                    default: begin
                        a = pool[$urandom_range(0, POOL_SIZE - 1)];
                        a[$urandom_range(0, ast_pkg::ADDR_W - 1)] ^= 1'b1;
                    end
                endcase
                if ($urandom_range(0, 99) == 0) begin
                    wait_table_idle();
                end
                send_address(a, 1'b0, unused_res);
            end
        end

        wait_table_idle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
